[hdl/fvn_pkg.sv]
// Shared types and constants for the fractal value noise core.
package fvn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = $clog2(MAX_OCTAVES);
  localparam int ROW_STRIDE  = 2677;
  localparam int AMP_W       = 17;
  localparam int LAT_W       = 26;
  localparam int FRAC_W      = 25;
  localparam int ACC_W       = 40;

  localparam logic [AMP_W-1:0] AMP_ONE  = 17'd65536;
  localparam logic [31:0]      HASH_A   = 32'd15731;
  localparam logic [31:0]      HASH_B   = 32'd122033;
  localparam logic [31:0]      HASH_C   = 32'd1376312589;
  localparam logic [31:0]      STRIDE32 = 32'(ROW_STRIDE);

  typedef enum logic [1:0] {
    REG_OCTAVE_COUNT   = 2'd0,
    REG_BASE_FREQUENCY = 2'd1,
    REG_PERSISTENCE    = 2'd2,
    REG_NOISE_SEED     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] noise_sum;
    logic               saturated;
  } out_item_t;

  // Per-octave beat control that travels with the data.
  typedef struct packed {
    logic valid;
    logic live;
    logic first;
    logic last;
    logic two_d;
  } beat_t;

  typedef logic signed [LAT_W-1:0] lat_t;

endpackage

[hdl/fvn_seq.sv]
// Octave sequencer: issues one octave beat per cycle with its amplitude.
module fvn_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  fvn_pkg::in_item_t             in_item,
  input  logic [3:0]                    octave_count,
  input  logic [15:0]                   persistence,
  output logic                          busy,
  output fvn_pkg::beat_t                beat,
  output logic [fvn_pkg::OCT_W-1:0]     beat_oct,
  output logic [fvn_pkg::AMP_W-1:0]     beat_amp,
  output logic signed [31:0]            beat_x,
  output logic signed [31:0]            beat_y
);

  logic                          act_r, act_nxt;
  logic [fvn_pkg::OCT_W-1:0]     oct_r, oct_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [fvn_pkg::AMP_W-1:0]     amp_r, amp_nxt;
  fvn_pkg::in_item_t             item_r, item_nxt;
  logic                          last_beat;
  logic                          accept;
  logic [3:0]                    cnt_cap;
  logic [32:0]                   amp_prod;

  assign cnt_cap   = (octave_count > 4'(fvn_pkg::MAX_OCTAVES)) ?
                     4'(fvn_pkg::MAX_OCTAVES) : octave_count;
  assign last_beat = act_r && ((cnt_r == 4'd0) || ({1'b0, oct_r} == cnt_r - 4'd1));
  assign busy      = act_r && !last_beat;
  assign accept    = start && !busy;
  assign amp_prod  = amp_r * persistence;

  always_comb begin
    act_nxt  = act_r;
    oct_nxt  = oct_r;
    cnt_nxt  = cnt_r;
    amp_nxt  = amp_r;
    item_nxt = item_r;
    if (accept) begin
      act_nxt  = 1'b1;
      oct_nxt  = '0;
      cnt_nxt  = cnt_cap;
      amp_nxt  = fvn_pkg::AMP_ONE;
      item_nxt = in_item;
    end else if (last_beat) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      oct_nxt = oct_r + 1'b1;
      amp_nxt = amp_prod[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
    oct_r  <= oct_nxt;
    cnt_r  <= cnt_nxt;
    amp_r  <= amp_nxt;
    item_r <= item_nxt;
  end

  assign beat.valid = act_r;
  assign beat.live  = (cnt_r != 4'd0);
  assign beat.first = (oct_r == '0);
  assign beat.last  = last_beat;
  assign beat.two_d = item_r.opcode;
  assign beat_oct   = oct_r;
  assign beat_amp   = amp_r;
  assign beat_x     = item_r.x_coord;
  assign beat_y     = item_r.y_coord;

endmodule

[hdl/fvn_lattice.sv]
// Coordinate split and 4x4 lattice hash lanes, eight register stages.
module fvn_lattice (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fvn_pkg::beat_t                beat,
  input  logic [fvn_pkg::OCT_W-1:0]     beat_oct,
  input  logic [fvn_pkg::AMP_W-1:0]     beat_amp,
  input  logic signed [31:0]            beat_x,
  input  logic signed [31:0]            beat_y,
  input  logic [23:0]                   base_frequency,
  input  logic [31:0]                   noise_seed,
  output fvn_pkg::beat_t                lat_beat,
  output logic [fvn_pkg::AMP_W-1:0]     lat_amp,
  output logic signed [fvn_pkg::FRAC_W-1:0] lat_fx,
  output logic signed [fvn_pkg::FRAC_W-1:0] lat_fy,
  output fvn_pkg::lat_t                 lat_val [4][4]
);

  localparam int NST = 8;

  fvn_pkg::beat_t              ctl_r [NST];
  logic [fvn_pkg::AMP_W-1:0]   amp_r [NST];

  // stage 1: magnitudes
  logic [31:0]                 magx_r, magy_r;
  logic                        negx_r, negy_r;
  logic [fvn_pkg::OCT_W-1:0]   oct1_r, oct2_r;
  // stage 2: products
  logic [55:0]                 px_r, py_r;
  logic                        negx2_r, negy2_r;
  // stage 3: split, fractions carried on to stage 8
  logic [31:0]                 ix_r, iy_r;
  logic signed [fvn_pkg::FRAC_W-1:0] fx_r [3:NST];
  logic signed [fvn_pkg::FRAC_W-1:0] fy_r [3:NST];
  // stage 4: lattice base
  logic [31:0]                 base_r;
  // stages 5..8: hash lanes
  logic [31:0]                 m5_r [4][4];
  logic [31:0]                 m6_r [4][4];
  logic [31:0]                 m7_r [4][4];
  logic [31:0]                 sq6_r [4][4];
  logic [31:0]                 t7_r [4][4];
  fvn_pkg::lat_t               val8_r [4][4];

  logic [62:0]                 shx, shy;
  logic [31:0]                 ipx, ipy;
  logic [5:0]                  rsh;

  assign rsh = 6'd40 - {3'b0, oct2_r};
  assign shx = {7'b0, px_r} << oct2_r;
  assign shy = {7'b0, py_r} << oct2_r;
  assign ipx = 32'(px_r >> rsh);
  assign ipy = 32'(py_r >> rsh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) ctl_r[s] <= '0;
    end else begin
      ctl_r[0] <= beat;
      for (int s = 1; s < NST; s++) ctl_r[s] <= ctl_r[s-1];
    end
    amp_r[0] <= beat_amp;
    for (int s = 1; s < NST; s++) amp_r[s] <= amp_r[s-1];

    // stage 1
    negx_r <= beat_x[31];
    negy_r <= beat_y[31];
    magx_r <= beat_x[31] ? (32'd0 - beat_x) : beat_x;
    magy_r <= beat_y[31] ? (32'd0 - beat_y) : beat_y;
    oct1_r <= beat_oct;
    // stage 2
    px_r    <= magx_r * base_frequency;
    py_r    <= magy_r * base_frequency;
    negx2_r <= negx_r;
    negy2_r <= negy_r;
    oct2_r  <= oct1_r;
    // stage 3
    ix_r     <= negx2_r ? (32'd0 - ipx) : ipx;
    iy_r     <= negy2_r ? (32'd0 - ipy) : ipy;
    fx_r[3]  <= negx2_r ? -$signed({1'b0, shx[39:16]}) : $signed({1'b0, shx[39:16]});
    fy_r[3]  <= negy2_r ? -$signed({1'b0, shy[39:16]}) : $signed({1'b0, shy[39:16]});
    for (int s = 4; s <= NST; s++) begin
      fx_r[s] <= fx_r[s-1];
      fy_r[s] <= fy_r[s-1];
    end
    // stage 4: 1D uses the row at offset zero, so the row term drops out
    base_r <= noise_seed + ix_r + (ctl_r[2].two_d ? iy_r * fvn_pkg::STRIDE32 : 32'd0);
    // stages 5..8
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        logic [31:0] n;
        n = base_r + 32'(i - 1) + 32'(j - 1) * fvn_pkg::STRIDE32;
        m5_r[j][i]  <= (n << 13) ^ n;
        sq6_r[j][i] <= m5_r[j][i] * m5_r[j][i];
        m6_r[j][i]  <= m5_r[j][i];
        t7_r[j][i]  <= sq6_r[j][i] * fvn_pkg::HASH_A + fvn_pkg::HASH_B;
        m7_r[j][i]  <= m6_r[j][i];
      end
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        logic [31:0] h;
        h = m7_r[j][i] * t7_r[j][i] + fvn_pkg::HASH_C;
        val8_r[j][i] <= fvn_pkg::lat_t'(27'sd16777216 - $signed({2'b0, h[30:6]}));
      end
    end
  end

  assign lat_beat = ctl_r[NST-1];
  assign lat_amp  = amp_r[NST-1];
  assign lat_fx   = fx_r[NST];
  assign lat_fy   = fy_r[NST];
  assign lat_val  = val8_r;

endmodule

[hdl/fvn_blend.sv]
// Smoothing, interpolation, amplitude weighting and octave accumulation.
module fvn_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fvn_pkg::beat_t                    lat_beat,
  input  logic [fvn_pkg::AMP_W-1:0]         lat_amp,
  input  logic signed [fvn_pkg::FRAC_W-1:0] lat_fx,
  input  logic signed [fvn_pkg::FRAC_W-1:0] lat_fy,
  input  fvn_pkg::lat_t                     lat_val [4][4],
  output logic                              out_valid,
  output fvn_pkg::out_item_t                out_item
);

  localparam int NST = 6;

  fvn_pkg::beat_t              ctl_r [NST];
  logic [fvn_pkg::AMP_W-1:0]   amp_r [NST-1];
  logic signed [fvn_pkg::FRAC_W-1:0] fx_r [1];
  logic signed [fvn_pkg::FRAC_W-1:0] fy_r [3];

  logic signed [31:0] f00_r, f10_r, f01_r, f11_r;
  logic signed [31:0] pa_r, pb_r, fa_r, fb_r;
  logic signed [31:0] a_r, b_r, a4_r;
  logic signed [63:0] pv_r;
  logic signed [31:0] v_r;
  logic signed [47:0] term_r;
  logic signed [fvn_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic               out_valid_r;
  fvn_pkg::out_item_t out_item_r;

  function automatic logic signed [31:0] sm2(input fvn_pkg::lat_t v [4][4],
                                              input int cy, input int cx);
    logic signed [31:0] s;
    s = 32'(v[cy][cx]) * 4
      + 32'(v[cy][cx-1]) * 2 + 32'(v[cy][cx+1]) * 2
      + 32'(v[cy-1][cx]) * 2 + 32'(v[cy+1][cx]) * 2
      + 32'(v[cy-1][cx-1]) + 32'(v[cy-1][cx+1])
      + 32'(v[cy+1][cx-1]) + 32'(v[cy+1][cx+1]);
    return s >>> 4;
  endfunction

  function automatic logic signed [31:0] sm1(input fvn_pkg::lat_t v [4][4], input int cx);
    logic signed [31:0] s;
    s = 32'(v[1][cx]) * 2 + 32'(v[1][cx-1]) + 32'(v[1][cx+1]);
    return s >>> 2;
  endfunction

  always_comb begin
    acc_nxt = (ctl_r[NST-1].first ? '0 : acc_r)
            + (ctl_r[NST-1].live ? fvn_pkg::ACC_W'(term_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) ctl_r[s] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r[0] <= lat_beat;
      for (int s = 1; s < NST; s++) ctl_r[s] <= ctl_r[s-1];
      out_valid_r <= ctl_r[NST-1].valid && ctl_r[NST-1].last;
    end
    amp_r[0] <= lat_amp;
    for (int s = 1; s < NST-1; s++) amp_r[s] <= amp_r[s-1];
    fx_r[0] <= lat_fx;
    fy_r[0] <= lat_fy;
    for (int s = 1; s < 3; s++) fy_r[s] <= fy_r[s-1];

    // smooth
    if (lat_beat.two_d) begin
      f00_r <= sm2(lat_val, 1, 1);
      f10_r <= sm2(lat_val, 1, 2);
      f01_r <= sm2(lat_val, 2, 1);
      f11_r <= sm2(lat_val, 2, 2);
    end else begin
      f00_r <= sm1(lat_val, 1);
      f10_r <= sm1(lat_val, 2);
      f01_r <= sm1(lat_val, 1);
      f11_r <= sm1(lat_val, 2);
    end
    // x products
    pa_r <= 32'(((64'(f10_r) - 64'(f00_r)) * 64'(fx_r[0])) >>> 24);
    pb_r <= 32'(((64'(f11_r) - 64'(f01_r)) * 64'(fx_r[0])) >>> 24);
    fa_r <= f00_r;
    fb_r <= f01_r;
    // x lerp
    a_r <= fa_r + pa_r;
    b_r <= fb_r + pb_r;
    // y product
    pv_r <= (64'(b_r) - 64'(a_r)) * 64'(fy_r[2]);
    a4_r <= a_r;
    // y lerp, 1D takes the x lerp as it is
    v_r <= ctl_r[3].two_d ? a4_r + 32'(pv_r >>> 24) : a4_r;
    // weight
    term_r <= (48'(v_r) * $signed({31'b0, amp_r[4]})) >>> 16;
    // accumulate and clip on the last octave
    if (ctl_r[NST-1].valid) acc_r <= acc_nxt;
    if (acc_nxt > 40'sd2147483647) begin
      out_item_r.noise_sum <= 32'sh7fffffff;
      out_item_r.saturated <= 1'b1;
    end else if (acc_nxt < -40'sd2147483648) begin
      out_item_r.noise_sum <= 32'sh80000000;
      out_item_r.saturated <= 1'b1;
    end else begin
      out_item_r.noise_sum <= 32'(acc_nxt);
      out_item_r.saturated <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hdl/fractal_value_noise_core.sv]
// Top level of the fractal value noise core.
//
// Input: present an item on in_item and raise start; it is taken at the clock
// edge where start is high and busy is low. opcode selects 1D or 2D noise.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register
// (octave count, base frequency, persistence, seed); write only while idle.
// Output: out_valid pulses for one cycle with out_item holding the noise sum
// and the clip flag. There is no back-pressure: the receiver takes every item.
//
// Throughput: one octave per cycle. An item occupies the sequencer for
// one beat per octave (a single beat for zero octaves), busy being high for
// all but the last of those beats, so items follow each other with no gap;
// the octave sequencer sets the rate. Results pass through the 8-stage hash
// pipe and the 7-stage blend pipe.
// Reset (synchronous, rst_n low) returns the registers to their defaults,
// drops any item in flight and clears busy and out_valid.
module fractal_value_noise_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fvn_pkg::in_item_t  in_item,
  output logic               out_valid,
  output fvn_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [3:0]  octave_count_r;
  logic [23:0] base_frequency_r;
  logic [15:0] persistence_r;
  logic [31:0] noise_seed_r;

  fvn_pkg::beat_t                    beat, lat_beat;
  logic [fvn_pkg::OCT_W-1:0]         beat_oct;
  logic [fvn_pkg::AMP_W-1:0]         beat_amp, lat_amp;
  logic signed [31:0]                beat_x, beat_y;
  logic signed [fvn_pkg::FRAC_W-1:0] lat_fx, lat_fy;
  fvn_pkg::lat_t                     lat_val [4][4];

  // hold configuration; write only the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r   <= 4'd6;
      base_frequency_r <= 24'd134218;
      persistence_r    <= 16'd32768;
      noise_seed_r     <= 32'd0;
    end else if (cfg_we) begin
      case (fvn_pkg::cfg_reg_t'(cfg_index))
        fvn_pkg::REG_OCTAVE_COUNT:   octave_count_r   <= cfg_wdata[3:0];
        fvn_pkg::REG_BASE_FREQUENCY: base_frequency_r <= cfg_wdata[23:0];
        fvn_pkg::REG_PERSISTENCE:    persistence_r    <= cfg_wdata[15:0];
        fvn_pkg::REG_NOISE_SEED:     noise_seed_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // issue one beat per octave, a single beat for zero octaves
  fvn_seq u_seq (
    .clk, .rst_n, .start, .in_item,
    .octave_count (octave_count_r),
    .persistence  (persistence_r),
    .busy, .beat, .beat_oct, .beat_amp, .beat_x, .beat_y
  );

  // split the coordinate and hash the 4x4 neighbourhood
  fvn_lattice u_lattice (
    .clk, .rst_n, .beat, .beat_oct, .beat_amp, .beat_x, .beat_y,
    .base_frequency (base_frequency_r),
    .noise_seed     (noise_seed_r),
    .lat_beat, .lat_amp, .lat_fx, .lat_fy, .lat_val
  );

  // smooth, interpolate, weight and sum
  fvn_blend u_blend (
    .clk, .rst_n, .lat_beat, .lat_amp, .lat_fx, .lat_fy, .lat_val,
    .out_valid, .out_item
  );

endmodule

[hdl/fvn_checker.sv]
// Port-level checks for the fractal value noise core, bound to the top level.
module fvn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input fvn_pkg::out_item_t out_item
);

  // a clipped sum sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.noise_sum == 32'sh7fffffff || out_item.noise_sum == 32'sh80000000)
    else $error("clipped sum off the rails");

  // reset drops the sequencer and the result strobe
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("reset left busy or a result");

  // reset clears the whole pipe, so nothing emerges right after reset
  a_rst_drain: assert property (@(posedge clk) $past(!rst_n, 2) |-> !out_valid)
    else $error("result too soon after reset");

endmodule

bind fractal_value_noise_core fvn_checker u_fvn_checker (
  .clk, .rst_n, .busy, .out_valid, .out_item
);

[bench/fvn_checker.sv]
// Checker for the fractal value noise core: predicts each noise sum and compares.
`timescale 1ns / 1ps
module fvn_scoreboard (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  fvn_pkg::in_item_t          in_item,
  input  logic                       out_valid,
  input  fvn_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_wdata,
  output int                         fails,
  output int                         pending,
  output int                         n_sums,
  output int                         n_clipped
);

  localparam logic [63:0] MASK40 = (64'd1 << 40) - 64'd1;

  logic [3:0]  oct_count;
  logic [23:0] base_freq;
  logic [15:0] persist;
  logic [31:0] seed;

  fvn_pkg::out_item_t noise_q[$];

  function automatic longint hash_value(logic [31:0] n);
    logic [31:0] m, h;
    m = (n << 13) ^ n;
    h = (m * (m * m * fvn_pkg::HASH_A + fvn_pkg::HASH_B) + fvn_pkg::HASH_C) & 32'h7fffffff;
    return 64'sd16777216 - longint'({32'd0, h >> 6});
  endfunction

  function automatic longint smooth_1d(logic [31:0] i);
    longint s;
    s = 2 * hash_value(seed + i) + hash_value(seed + i - 32'd1) + hash_value(seed + i + 32'd1);
    return s >>> 2;
  endfunction

  function automatic longint smooth_2d(logic [31:0] x, logic [31:0] y);
    longint s;
    logic [31:0] xx, yy;
    s = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        xx = x + 32'(dx);
        yy = y + 32'(dy);
        s += longint'((dx == 0 ? 2 : 1) * (dy == 0 ? 2 : 1)) *
             hash_value(seed + xx + yy * fvn_pkg::STRIDE32);
      end
    end
    return s >>> 4;
  endfunction

  function automatic longint blend(longint f0, longint f1, longint d);
    return f0 + (((f1 - f0) * d) >>> 24);
  endfunction

  // Split a Q16.16 coordinate scaled by the octave frequency into lattice
  // index (truncated toward zero) and signed Q0.24 fraction.
  function automatic void split_coord(logic [31:0] c, int oct,
                                      output logic [31:0] idx, output longint frac);
    logic [31:0] mag;
    logic [63:0] p, ip, fr;
    mag = c[31] ? (32'd0 - c) : c;
    p = {32'd0, mag} * {40'd0, base_freq};
    ip = p >> (40 - oct);
    fr = ((p << oct) & MASK40) >> 16;
    idx = c[31] ? (32'd0 - ip[31:0]) : ip[31:0];
    frac = c[31] ? -longint'(fr) : longint'(fr);
  endfunction

  function automatic fvn_pkg::out_item_t noise_sum_of(fvn_pkg::in_item_t it);
    fvn_pkg::out_item_t r;
    longint sum, v, fx, fy, a, b;
    logic [63:0] amp;
    logic [31:0] ix, iy;
    int count;
    count = (oct_count > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : int'(oct_count);
    sum = 0;
    amp = 64'd65536;
    for (int oct = 0; oct < count; oct++) begin
      split_coord(it.x_coord, oct, ix, fx);
      if (it.opcode) begin
        split_coord(it.y_coord, oct, iy, fy);
        a = blend(smooth_2d(ix, iy), smooth_2d(ix + 32'd1, iy), fx);
        b = blend(smooth_2d(ix, iy + 32'd1), smooth_2d(ix + 32'd1, iy + 32'd1), fx);
        v = blend(a, b, fy);
      end else begin
        v = blend(smooth_1d(ix), smooth_1d(ix + 32'd1), fx);
      end
      sum += (v * longint'(amp)) >>> 16;
      amp = (amp * {48'd0, persist}) >> 16;
    end
    r.saturated = 1'b1;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    else r.saturated = 1'b0;
    r.noise_sum = sum[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  initial begin
    fails = 0;
    n_sums = 0;
    n_clipped = 0;
  end

  assign pending = noise_q.size();

  always @(posedge clk) begin
    fvn_pkg::out_item_t exp_item;
    if (!rst_n) begin
      oct_count <= 4'd6;
      base_freq <= 24'd134218;
      persist   <= 16'd32768;
      seed      <= 32'd0;
      noise_q.delete();
    end else begin
      if (cfg_we) begin
        case (fvn_pkg::cfg_reg_t'(cfg_index))
          fvn_pkg::REG_OCTAVE_COUNT:   oct_count <= cfg_wdata[3:0];
          fvn_pkg::REG_BASE_FREQUENCY: base_freq <= cfg_wdata[23:0];
          fvn_pkg::REG_PERSISTENCE:    persist   <= cfg_wdata[15:0];
          fvn_pkg::REG_NOISE_SEED:     seed      <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) noise_q.push_back(noise_sum_of(in_item));
      if (out_valid) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item sum=%h", out_item.noise_sum));
        end else begin
          exp_item = noise_q.pop_front();
          n_sums++;
          if (exp_item.saturated) n_clipped++;
          if (out_item.noise_sum !== exp_item.noise_sum)
            report_mismatch($sformatf("noise_sum %h, want %h",
                                      out_item.noise_sum, exp_item.noise_sum));
          if (out_item.saturated !== exp_item.saturated)
            report_mismatch($sformatf("saturated %b, want %b",
                                      out_item.saturated, exp_item.saturated));
        end
      end
    end
  end
endmodule

[bench/tb.sv]
// Top of the fractal value noise testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  fvn_pkg::in_item_t  in_item;
  logic      out_valid;
  fvn_pkg::out_item_t out_item;
  logic      cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int fails, pending, n_sums, n_clipped;
  int n_1d, n_2d, n_phases;
  bit burst;

  always #1 clk = ~clk;

  fractal_value_noise_core u_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  fvn_scoreboard u_chk (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fails, .pending, .n_sums, .n_clipped
  );

  // Hold start low for a random gap; mostly short, now and then long.
  // In a burst phase, never idle.
  task automatic idle_gap();
    int r, len;
    r = $urandom_range(99);
    if (burst || r < 50) return;
    len = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start <= 1'b0;
    repeat (len) @(posedge clk);
  endtask

  // Present one item and wait for the edge that takes it.
  task automatic send_item(logic two_d, logic [31:0] x, logic [31:0] y);
    start <= 1'b1;
    in_item <= '{opcode: two_d, x_coord: x, y_coord: y};
    do @(posedge clk); while (busy);
    if (two_d) n_2d++; else n_1d++;
    idle_gap();
  endtask

  // Coordinate with a mix of sizes: near zero, moderate, full range, extremes.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      4, 5, 6: return $urandom_range(0, 32'h1ff_ffff) - 32'h100_0000;
      default: return $urandom;
    endcase
  endfunction

  // Wait for the block to drain, let the pipe settle, then write one register.
  task automatic write_reg(fvn_pkg::cfg_reg_t idx, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [3:0] oc, logic [23:0] bf, logic [15:0] pe, logic [31:0] sd);
    write_reg(fvn_pkg::REG_OCTAVE_COUNT, {28'd0, oc});
    write_reg(fvn_pkg::REG_BASE_FREQUENCY, {8'd0, bf});
    write_reg(fvn_pkg::REG_PERSISTENCE, {16'd0, pe});
    write_reg(fvn_pkg::REG_NOISE_SEED, sd);
    n_phases++;
  endtask

  task automatic random_items(int count);
    burst = ($urandom_range(3) == 0);
    repeat (count) send_item(1'($urandom_range(1)), pick_coord(), pick_coord());
    burst = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = fvn_pkg::REG_OCTAVE_COUNT;
    cfg_wdata = '0;
    n_1d = 0;
    n_2d = 0;
    n_phases = 0;
    burst = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset settings: field extremes, both modes,
    // positive and negative fractions, lattice boundaries.
    send_item(1'b0, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000);
    send_item(1'b0, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(1'b0, 32'h8000_0000, 32'h0000_0000);
    send_item(1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff);
    send_item(1'b0, 32'hffff_ffff, 32'h1234_5678);
    send_item(1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_item(1'b0, 32'h0001_0000, 32'h0);
    send_item(1'b1, 32'hfff0_0000, 32'h0010_0000);
    send_item(1'b0, 32'h0000_0001, 32'h0);
    send_item(1'b1, 32'h5555_5555, 32'haaaa_aaaa);

    // Extreme settings: big sums at full frequency and persistence, zero octaves, count
    // above the cap, zero frequency and persistence.
    set_config(4'd8, 24'hff_ffff, 16'hffff, 32'hffff_ffff);
    send_item(1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(1'b0, 32'h8000_0000, 32'h0);
    random_items(150);
    set_config(4'd0, 24'd134218, 16'd32768, 32'h8000_0000);
    send_item(1'b0, 32'h1234_5678, 32'h0);
    send_item(1'b1, 32'hdead_beef, 32'h0bad_f00d);
    random_items(40);
    set_config(4'd15, 24'd0, 16'd0, 32'h7fff_ffff);
    send_item(1'b1, 32'h0, 32'h0);
    random_items(80);
    set_config(4'd1, 24'd1, 16'd65535, 32'd0);
    random_items(120);
    set_config(4'd8, 24'h80_0000, 16'hffff, 32'h0);
    random_items(150);
    set_config(4'd9, 24'hff_ffff, 16'hc000, 32'h0000_0001);
    random_items(120);

    // Random settings for the rest of the run.
    repeat (5) begin
      set_config(4'($urandom_range(15)), 24'($urandom), 16'($urandom), $urandom);
      random_items(100);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d 1D and %0d 2D items over %0d register settings;",
             n_1d, n_2d, n_phases + 1);
    $display("%0d sums checked, %0d of them clipped.", n_sums, n_clipped);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule
